>>> design/qspwm_pkg.sv
package qspwm_pkg;

	// Quarter-wave table resolution and time base width
	localparam int SINE_TABLE_BITS = 8;
	localparam int COUNT_WIDTH     = 16;

	localparam int TABLE_N = 1 << SINE_TABLE_BITS;

	// Field and register widths
	localparam int COUNT_FIELD_W = 16;
	localparam int STEP_W        = 32;
	localparam int AMP_W         = 16;
	localparam int MAG_W         = 16;
	localparam int DUTY_W        = 16;
	localparam int CFG_DATA_W    = 32;

	// Count bits that reach the multiplier
	localparam int CNT_BITS = (COUNT_WIDTH < COUNT_FIELD_W) ? COUNT_WIDTH : COUNT_FIELD_W;

	// pi/2 in Q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Register indexes on the configuration port
	typedef enum logic {
		REG_PHASE_STEP = 1'b0,
		REG_AMPLITUDE  = 1'b1
	} cfg_reg_t;

	typedef logic [MAG_W-1:0] sine_table_t [0:TABLE_N];

	// Taylor term divisors (2k)(2k+1) for k = 1..7
	typedef longint unsigned taylor_div_t [0:6];
	localparam taylor_div_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	// One Q15 entry of sin(pi/2 * i / N), Q30 Taylor series
	function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i);
		longint unsigned x;
		longint unsigned t;
		longint sum;
		longint unsigned q;
		x = (HALF_PI_Q30 * longint'(i)) >> SINE_TABLE_BITS;
		t = x;
		sum = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			t = (t * x) >> 30;
			t = (t * x) >> 30;
			t = t / TAYLOR_DIV[k-1];
			if ((k % 2) == 1) begin
				sum = sum - longint'(t);
			end else begin
				sum = sum + longint'(t);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = (longint'(sum) + 64'd16384) >> 15;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return q[MAG_W-1:0];
	endfunction

	function automatic sine_table_t build_sine_table();
		sine_table_t tbl;
		for (int i = 0; i <= TABLE_N; i++) begin
			tbl[i] = sine_entry(i);
		end
		return tbl;
	endfunction

	localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

>>> design/quadrature_sine_pwm_duty_top.sv
// A start transfer moves through the registers valid_s1 and valid_s2 to valid_s3, which drives its done strobe.
// Throughput: one timer sample per cycle; busy is never raised.
// Stages: angle multiply, quarter-wave table lookup, amplitude multiply and steering.
// The receiver cannot stall: each result shows for one cycle with done.
// Reset (arst_n low, asynchronous) clears the stage valid bits and both
// configuration registers to zero.
module quadrature_sine_pwm_duty_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [qspwm_pkg::COUNT_FIELD_W-1:0]  timer_count,
	output logic                                 done,
	output logic [qspwm_pkg::DUTY_W-1:0]         duty_a_pos,
	output logic [qspwm_pkg::DUTY_W-1:0]         duty_a_neg,
	output logic [qspwm_pkg::DUTY_W-1:0]         duty_b_pos,
	output logic [qspwm_pkg::DUTY_W-1:0]         duty_b_neg,
	input  logic                                 cfg_wr_en,
	input  qspwm_pkg::cfg_reg_t                  cfg_addr,
	input  logic [qspwm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import qspwm_pkg::*;

	localparam int PROD_W = CNT_BITS + STEP_W;
	localparam int MUL_W  = AMP_W + MAG_W;
	localparam logic [SINE_TABLE_BITS:0] TABLE_LAST = (SINE_TABLE_BITS+1)'(TABLE_N);

	logic [STEP_W-1:0] phase_step_q;
	logic [AMP_W-1:0]  amplitude_q;

	logic              valid_s1;
	logic [STEP_W-1:0] angle_s1;

	logic              valid_s2;
	logic [MAG_W-1:0]  mag_a_s2;
	logic [MAG_W-1:0]  mag_b_s2;
	logic              neg_a_s2;
	logic              neg_b_s2;

	logic              valid_s3;

	logic [CNT_BITS-1:0] count_in;
	logic [PROD_W-1:0]   angle_prod;

	logic [1:0]                 quad_a;
	logic [1:0]                 quad_b;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [SINE_TABLE_BITS:0]   idx_up;
	logic [SINE_TABLE_BITS:0]   idx_down;
	logic [MAG_W-1:0]           mag_up;
	logic [MAG_W-1:0]           mag_down;
	logic [MAG_W-1:0]           mag_a;
	logic [MAG_W-1:0]           mag_b;

	logic [MUL_W-1:0]  prod_a;
	logic [MUL_W-1:0]  prod_b;
	logic [DUTY_W-1:0] duty_a;
	logic [DUTY_W-1:0] duty_b;

	assign busy = 1'b0;
	assign done = valid_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			amplitude_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_PHASE_STEP: phase_step_q <= cfg_wdata[STEP_W-1:0];
				REG_AMPLITUDE:  amplitude_q  <= cfg_wdata[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: angle = count * phase_step, wraps at one turn
	assign count_in   = timer_count[CNT_BITS-1:0];
	assign angle_prod = PROD_W'(count_in) * PROD_W'(phase_step_q);

	// Stage 2: quarter-wave lookup; both phases share the same offset in quadrant
	assign quad_a   = angle_s1[STEP_W-1 -: 2];
	assign quad_b   = quad_a + 2'd1;
	assign idx      = angle_s1[STEP_W-3 -: SINE_TABLE_BITS];
	assign idx_up   = {1'b0, idx};
	assign idx_down = TABLE_LAST - idx_up;
	assign mag_up   = SINE_TABLE[idx_up];
	assign mag_down = SINE_TABLE[idx_down];
	assign mag_a    = quad_a[0] ? mag_down : mag_up;
	assign mag_b    = quad_b[0] ? mag_down : mag_up;

	// Stage 3: scale by amplitude; Q15 product peaks at 65535, no clamp needed
	assign prod_a = MUL_W'(amplitude_q) * MUL_W'(mag_a_s2);
	assign prod_b = MUL_W'(amplitude_q) * MUL_W'(mag_b_s2);
	assign duty_a = prod_a[15 +: DUTY_W];
	assign duty_b = prod_b[15 +: DUTY_W];

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		angle_s1 <= angle_prod[STEP_W-1:0];
		mag_a_s2 <= mag_a;
		mag_b_s2 <= mag_b;
		neg_a_s2 <= quad_a[1] && (mag_a != '0);
		neg_b_s2 <= quad_b[1] && (mag_b != '0);
		duty_a_pos <= neg_a_s2 ? '0 : duty_a;
		duty_a_neg <= neg_a_s2 ? duty_a : '0;
		duty_b_pos <= neg_b_s2 ? '0 : duty_b;
		duty_b_neg <= neg_b_s2 ? duty_b : '0;
	end

endmodule

>>> design/qspwm_checker.sv
module qspwm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic [qspwm_pkg::DUTY_W-1:0]        duty_a_pos,
	input logic [qspwm_pkg::DUTY_W-1:0]        duty_a_neg,
	input logic [qspwm_pkg::DUTY_W-1:0]        duty_b_pos,
	input logic [qspwm_pkg::DUTY_W-1:0]        duty_b_neg
);
	import qspwm_pkg::*;

	// Every accepted sample yields a result with done
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("accepted sample produced no result");

	// No result without a matching accepted transfer
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching transfer");

	// The pipeline takes a sample every cycle
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// Only one side of each bridge pair is driven
	a_phase_a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (duty_a_pos == '0) || (duty_a_neg == '0))
		else $error("phase A drives both sides");

	a_phase_b_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (duty_b_pos == '0) || (duty_b_neg == '0))
		else $error("phase B drives both sides");

endmodule

bind quadrature_sine_pwm_duty_top qspwm_checker u_qspwm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.duty_a_pos (duty_a_pos),
	.duty_a_neg (duty_a_neg),
	.duty_b_pos (duty_b_pos),
	.duty_b_neg (duty_b_neg)
);
